FILE: rtl/bfr_pkg.sv
// bfr_pkg: shared types and constants of the bitmap font text renderer
// glyph geometry, register indexes, queue entry and pixel run layouts
// no dependencies
`default_nettype none
package bfr_pkg;

	localparam int GLYPH_HEIGHT  = 16;
	localparam int GLYPH_STEP_W  = 4;
	localparam int CURSOR_W      = 13;
	localparam int COORD_MAX_W   = 12;
	localparam int FONT_ADDR_W   = 11;
	localparam int GLYPH_W       = 7;
	localparam int CFG_INDEX_W   = 3;
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7e;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_LEFT      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_TOP       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_WIDTH     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_HEIGHT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

	// configuration seen by front and back, zero extended to the widest coordinate
	typedef struct packed {
		logic [COORD_MAX_W-1:0] box_left;
		logic [COORD_MAX_W-1:0] box_top;
		logic [COORD_MAX_W-1:0] box_width;
		logic [COORD_MAX_W-1:0] box_height;
		logic [COORD_MAX_W-1:0] screen_width;
		logic [COORD_MAX_W-1:0] screen_height;
	} cfg_t;

	// one job between front and back: a font byte write or a glyph draw
	typedef struct packed {
		logic                   is_load;
		logic [FONT_ADDR_W-1:0] addr;
		logic [7:0]             data;
		logic [GLYPH_W-1:0]     glyph;
		logic [CURSOR_W-1:0]    x;
		logic [CURSOR_W-1:0]    y;
	} job_t;

	// one pixel run on the result side
	typedef struct packed {
		logic [11:0] column_x;
		logic [11:0] top_row;
		logic [7:0]  pixel_bits;
		logic [3:0]  rows_valid;
		logic        last;
	} run_t;

endpackage
`default_nettype wire

FILE: rtl/bfr_fifo.sv
// bfr_fifo: small first-in first-out queue on registers
// used between front and back and on the result side; no package dependency
`default_nettype none
module bfr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           din,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                dout,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = store_q[rd_ptr_q];
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			store_q[wr_ptr_q] <= din;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bfr_front.sv
// bfr_front: accepts input transactions, keeps the text cursor and string state,
// and turns loads and printable characters into jobs; depends on bfr_pkg
`default_nettype none
module bfr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bfr_pkg::cfg_t       cfg,
	input  wire logic                accept,
	input  wire logic                kind,
	input  wire logic                first_char,
	input  wire logic [10:0]         font_address,
	input  wire logic [7:0]          font_data,
	input  wire logic [7:0]          char_code,
	input  wire logic [11:0]         font_depth,
	output logic                     job_push,
	output bfr_pkg::job_t            job
);
	localparam int CW = bfr_pkg::CURSOR_W;

	logic [CW-1:0] cursor_x_q;
	logic [CW-1:0] cursor_y_q;
	logic          stopped_q;

	logic [CW-1:0] cx0, cy0, cx_w, cy_w, cy_down;
	logic          stop0, printable, wrap, at_bottom, load_ok;
	logic [CW:0]   right_edge, bottom_edge;

	// cursor as seen by this character, after a string restart and a wrap
	always_comb begin
		cx0         = first_char ? CW'(cfg.box_left) : cursor_x_q;
		cy0         = first_char ? CW'(cfg.box_top) : cursor_y_q;
		stop0       = first_char ? 1'b0 : stopped_q;
		printable   = (char_code >= bfr_pkg::CHAR_FIRST) && (char_code <= bfr_pkg::CHAR_LAST);
		right_edge  = (CW+1)'(cfg.box_left) + (CW+1)'(cfg.box_width);
		bottom_edge = (CW+1)'(cfg.box_top) + (CW+1)'(cfg.box_height);
		wrap        = ({1'b0, cx0} >= right_edge);
		cy_down     = cy0 + CW'(bfr_pkg::GLYPH_HEIGHT);
		cx_w        = wrap ? CW'(cfg.box_left) : cx0;
		cy_w        = wrap ? cy_down : cy0;
		at_bottom   = ({1'b0, cy_w} >= bottom_edge);
		load_ok     = ({1'b0, font_address} < font_depth);
	end

	// job to the back
	always_comb begin
		job.is_load = !kind;
		job.addr    = font_address;
		job.data    = font_data;
		job.glyph   = bfr_pkg::GLYPH_W'(char_code - bfr_pkg::CHAR_FIRST);
		job.x       = cx_w;
		job.y       = cy_w;
		if (!kind) begin
			job_push = accept && load_ok;
		end else begin
			job_push = accept && !stop0 && printable && !at_bottom;
		end
	end

	// cursor and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			stopped_q  <= 1'b1;
		end else if (accept && kind) begin
			if (stop0 || !printable) begin
				cursor_x_q <= cx0;
				cursor_y_q <= cy0;
				stopped_q  <= 1'b1;
			end else if (at_bottom) begin
				cursor_x_q <= cx_w;
				cursor_y_q <= cy_w;
				stopped_q  <= 1'b1;
			end else begin
				cursor_x_q <= cx_w + CW'(bfr_pkg::GLYPH_HEIGHT / 2);
				cursor_y_q <= cy_w;
				stopped_q  <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bfr_back.sv
// bfr_back: carries out jobs, holds the font memory and steps through up to the
// sixteen bytes of a glyph, one pixel run a cycle while the result queue has room; depends on bfr_pkg
`default_nettype none
module bfr_back #(
	parameter int GLYPH_COUNT = 95,
	parameter int OUT_DEPTH   = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bfr_pkg::cfg_t                  cfg,
	input  wire bfr_pkg::job_t                  job,
	input  wire logic                           job_empty,
	output logic                                job_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                                run_push,
	output bfr_pkg::run_t                       run
);
	localparam int FONT_DEPTH = GLYPH_COUNT * bfr_pkg::GLYPH_HEIGHT;
	localparam int MEM_AW     = $clog2(FONT_DEPTH);
	localparam int CNT_W      = $clog2(OUT_DEPTH+1);
	localparam int CW         = bfr_pkg::CURSOR_W;
	localparam int PW         = CW + 1;
	localparam int TW         = bfr_pkg::GLYPH_STEP_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DRAW = 2'b10
	} back_state_t;

	logic [7:0] font_mem_q [FONT_DEPTH];

	back_state_t                   state_q;
	logic [bfr_pkg::GLYPH_W-1:0]   glyph_q;
	logic [CW-1:0]                 x_q, y_q;
	logic [TW-1:0]                 step_q;

	logic                          valid_s1, glyph_ok_s1;
	logic [7:0]                    data_s1;
	logic [11:0]                   col_s1, row_s1;
	logic [3:0]                    rows_s1;
	logic                          last_s1;

	logic          room, issue, stop, glyph_ok;
	logic [PW-1:0] col, row, sw, sh;
	logic [3:0]    rows;
	logic [11:0]   rd_full;

	// a run is issued only when the result queue can take it next cycle
	assign room  = ((CNT_W+1)'(out_count) + (CNT_W+1)'(valid_s1)) < (CNT_W+1)'(OUT_DEPTH);
	assign issue = (state_q == ST_DRAW) && room;

	// run geometry and clipping for the current glyph byte
	always_comb begin
		sw   = PW'(cfg.screen_width);
		sh   = PW'(cfg.screen_height);
		col  = {1'b0, x_q} + PW'(step_q[TW-1:1]);
		row  = {1'b0, y_q} + PW'({step_q[0], 3'b000});
		stop = 1'b1;
		rows = 4'd1;
		if (row + PW'(1) >= sh) begin
			rows = 4'd1;
		end else if (row + PW'(8) < sh) begin
			rows = 4'd8;
			stop = step_q[0] && (col + PW'(1) >= sw);
		end else begin
			rows = 4'((sh - row));
		end
		if (step_q == TW'(bfr_pkg::GLYPH_HEIGHT - 1)) begin
			stop = 1'b1;
		end
		glyph_ok = (32'(glyph_q) < GLYPH_COUNT);
		rd_full  = {1'b0, glyph_q, step_q};
	end

	assign job_pop = !job_empty && ((state_q == ST_IDLE) || (issue && stop));

	// job sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else if (job_pop) begin
			step_q  <= '0;
			state_q <= job.is_load ? ST_IDLE : ST_DRAW;
		end else begin
			case (state_q)
				ST_IDLE: begin
				end
				ST_DRAW: begin
					if (issue) begin
						step_q <= step_q + 1'b1;
						if (stop) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// current glyph job
	always_ff @(posedge clk) begin
		if (job_pop && !job.is_load) begin
			glyph_q <= job.glyph;
			x_q     <= job.x;
			y_q     <= job.y;
		end
	end

	// font memory: one write port for loads, one registered read for runs
	always_ff @(posedge clk) begin
		if (job_pop && job.is_load) begin
			font_mem_q[MEM_AW'({1'b0, job.addr})] <= job.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1 <= font_mem_q[MEM_AW'(rd_full)];
		end
	end

	// run stage beside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			glyph_ok_s1 <= glyph_ok;
			col_s1      <= col[11:0];
			row_s1      <= row[11:0];
			rows_s1     <= rows;
			last_s1     <= stop;
		end
	end

	assign run_push       = valid_s1;
	assign run.column_x   = col_s1;
	assign run.top_row    = row_s1;
	assign run.pixel_bits = glyph_ok_s1 ? data_s1 : 8'h00;
	assign run.rows_valid = rows_s1;
	assign run.last       = last_s1;
endmodule
`default_nettype wire

FILE: rtl/bitmap_font_text_renderer.sv
// bitmap_font_text_renderer: top level, configuration registers, front, job
// queue, back and result queue; depends on bfr_pkg, bfr_fifo, bfr_front, bfr_back
//
//   channel   signals                                        handshake
//   input     kind first_char font_address font_data char_code  push / full
//   result    column_x top_row pixel_bits rows_valid last     empty / pop
//   config    cfg_write cfg_index cfg_data                   write, no wait
//
// A character item steps through up to 16 glyph bytes in the back, one font
// memory read and one pixel run per cycle while the result queue has room. The
// next job is fetched in the cycle of the last run, so characters follow one
// another without a gap. A font load is written as its job leaves the queue;
// a run is registered with its memory read. Reset clears cursor, string
// state and queues; font memory holds nothing until written. A full result
// queue stalls the back only; the front keeps accepting until the job queue fills.
`default_nettype none
module bitmap_font_text_renderer #(
	parameter int GLYPH_COUNT = 95,
	parameter int COORD_BITS  = 11
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              kind,
	input  wire logic                              first_char,
	input  wire logic [10:0]                       font_address,
	input  wire logic [7:0]                        font_data,
	input  wire logic [7:0]                        char_code,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [11:0]                            column_x,
	output logic [11:0]                            top_row,
	output logic [7:0]                             pixel_bits,
	output logic [3:0]                             rows_valid,
	output logic                                   last,
	input  wire logic                              cfg_write,
	input  wire logic [bfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [COORD_BITS-1:0]             cfg_data
);
	localparam int JOB_DEPTH  = 4;
	localparam int OUT_DEPTH  = 4;
	localparam int FONT_DEPTH = GLYPH_COUNT * bfr_pkg::GLYPH_HEIGHT;
	localparam int JOB_W      = $bits(bfr_pkg::job_t);
	localparam int RUN_W      = $bits(bfr_pkg::run_t);
	localparam int MW         = bfr_pkg::COORD_MAX_W;

	logic [COORD_BITS-1:0] box_left_q, box_top_q, box_width_q, box_height_q;
	logic [COORD_BITS-1:0] screen_width_q, screen_height_q;
	bfr_pkg::cfg_t         cfg;

	bfr_pkg::job_t job_in, job_out;
	logic [JOB_W-1:0] job_out_vec;
	logic          job_push, job_full, job_pop, job_empty;
	logic [$clog2(JOB_DEPTH+1)-1:0] job_count;

	bfr_pkg::run_t run_in, run_out;
	logic [RUN_W-1:0] run_out_vec;
	logic          run_push, out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q      <= '0;
			box_top_q       <= '0;
			box_width_q     <= COORD_BITS'(200);
			box_height_q    <= COORD_BITS'(16);
			screen_width_q  <= COORD_BITS'(800);
			screen_height_q <= COORD_BITS'(480);
		end else if (cfg_write) begin
			case (cfg_index)
				bfr_pkg::REG_BOX_LEFT:      box_left_q      <= cfg_data;
				bfr_pkg::REG_BOX_TOP:       box_top_q       <= cfg_data;
				bfr_pkg::REG_BOX_WIDTH:     box_width_q     <= cfg_data;
				bfr_pkg::REG_BOX_HEIGHT:    box_height_q    <= cfg_data;
				bfr_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				bfr_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.box_left      = MW'(box_left_q);
		cfg.box_top       = MW'(box_top_q);
		cfg.box_width     = MW'(box_width_q);
		cfg.box_height    = MW'(box_height_q);
		cfg.screen_width  = MW'(screen_width_q);
		cfg.screen_height = MW'(screen_height_q);
	end

	assign full = job_full;

	// front: cursor, string state and classification
	bfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (push && !job_full),
		.kind         (kind),
		.first_char   (first_char),
		.font_address (font_address),
		.font_data    (font_data),
		.char_code    (char_code),
		.font_depth   (12'(FONT_DEPTH)),
		.job_push     (job_push),
		.job          (job_in)
	);

	// job queue between front and back
	bfr_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out_vec),
		.empty  (job_empty),
		.count  (job_count)
	);

	assign job_out = bfr_pkg::job_t'(job_out_vec);

	// back: font memory and glyph stepping
	bfr_back #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.OUT_DEPTH   (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.out_count (out_count),
		.run_push  (run_push),
		.run       (run_in)
	);

	// result queue
	bfr_fifo #(
		.WIDTH (RUN_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (run_push),
		.din    (run_in),
		.full   (out_full),
		.pop    (pop),
		.dout   (run_out_vec),
		.empty  (empty),
		.count  (out_count)
	);

	assign run_out    = bfr_pkg::run_t'(run_out_vec);
	assign column_x   = run_out.column_x;
	assign top_row    = run_out.top_row;
	assign pixel_bits = run_out.pixel_bits;
	assign rows_valid = run_out.rows_valid;
	assign last       = run_out.last;

`ifndef SYNTHESIS
	// the back never pushes a run that the result queue cannot hold
	a_no_run_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(run_push && out_full))
		else $error("run pushed into full result queue");

	// a waiting result always draws between one and eight rows
	a_rows_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rows_valid >= 4'd1 && rows_valid <= 4'd8))
		else $error("rows_valid out of range");

	// the job queue level stays within its depth
	a_job_level: assert property (@(posedge clk) disable iff (!arst_n)
		job_count <= 3'(JOB_DEPTH))
		else $error("job queue level beyond depth");

	// a run that is not the last of a short row range has all eight rows
	a_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (rows_valid == 4'd8))
		else $error("clipped run not marked last");
`endif
endmodule
`default_nettype wire
